[src/scs_pkg.sv]
`timescale 1ns / 1ps

package scs_pkg;

    localparam int SERIES_TERMS_DEF    = 10;
    localparam int ANGLE_FRAC_BITS_DEF = 24;
    localparam int TABLE_SIZE          = 16;

    localparam int ANGLE_W    = 32;
    localparam int OUT_W      = 32;
    localparam int WORK_FRAC  = 29;   // Q29 working format
    localparam int INV_W      = 30;   // width of 1/(2 pi) in Q0.32
    localparam int INV_FRAC   = 32;
    localparam int RED_W      = 36;   // raw reduced angle, before folding
    localparam int R_W        = 32;   // folded angle, |r| <= pi
    localparam int RMAG_W     = 31;
    localparam int MAG_W      = 33;   // term magnitudes
    localparam int X2_W       = 33;   // r squared
    localparam int RECIP_W    = 32;
    localparam int RECIP_FRAC = 32;
    localparam int SUM_W      = 36;   // partial sums, Q29 signed

    localparam logic [INV_W-1:0]        INV_TWO_PI_Q32 = 30'd683565276;
    localparam logic [31:0]             TWO_PI_Q29     = 32'd3373259426;
    localparam logic signed [RED_W-1:0] PI_RED         = 36'sd1686629713;
    localparam logic signed [RED_W-1:0] TWO_PI_RED     = 36'sd3373259426;
    localparam logic [MAG_W-1:0]        ONE_Q29        = 33'd536870912;

    localparam logic [OUT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MIN = 32'h8000_0000;

    // round(2^32 / ((2n+2)(2n+3)))
    localparam logic [RECIP_W-1:0] SINE_RECIP [TABLE_SIZE] = '{
        32'd715827883, 32'd214748365, 32'd102261126, 32'd59652324,
        32'd39045157,  32'd27531842,  32'd20452225,  32'd15790321,
        32'd12558384,  32'd10226113,  32'd8488078,   32'd7158279,
        32'd6118187,   32'd5289369,   32'd4618244,   32'd4067204
    };

    // round(2^32 / ((2n+1)(2n+2)))
    localparam logic [RECIP_W-1:0] COSINE_RECIP [TABLE_SIZE] = '{
        32'd2147483648, 32'd357913941, 32'd143165577, 32'd76695845,
        32'd47721859,   32'd32537631,  32'd23598721,  32'd17895697,
        32'd14035841,   32'd11302546,  32'd9296466,   32'd7780738,
        32'd6607642,    32'd5681174,   32'd4936744,   32'd4329604
    };

endpackage

[src/sine_cosine_series_unit.sv]
`timescale 1ns / 1ps

// Throughput: one angle per cycle while not stalled; each stage holds at most one multiplier per lane.
// A stalled result stops only the stages behind it, so s_ready stays high while any
// stage is empty.
// Reset (aresetn low, synchronous) clears the stage valid bits; data registers are not reset.
module sine_cosine_series_unit #(
    parameter int SERIES_TERMS    = scs_pkg::SERIES_TERMS_DEF,
    parameter int ANGLE_FRAC_BITS = scs_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [scs_pkg::ANGLE_W-1:0]   s_angle,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [scs_pkg::OUT_W-1:0]     m_sine_value,
    output logic signed [scs_pkg::OUT_W-1:0]     m_cosine_value
);

    localparam int NT = (SERIES_TERMS < scs_pkg::TABLE_SIZE) ? SERIES_TERMS
                                                              : scs_pkg::TABLE_SIZE;
    localparam int A0     = 5;          // first series stage
    localparam int NS     = 2 * NT + 5; // total stages, output register included
    localparam int PROD_W = scs_pkg::ANGLE_W + scs_pkg::INV_W + 1;
    localparam int SHIFT  = ANGLE_FRAC_BITS + scs_pkg::INV_FRAC;
    localparam int K_W    = PROD_W - SHIFT;
    localparam int KM_W   = K_W + 33;
    localparam int ASH_SH = scs_pkg::WORK_FRAC - ANGLE_FRAC_BITS;
    localparam int ASH_W  = scs_pkg::ANGLE_W + ASH_SH;
    localparam int SQ_W   = 2 * scs_pkg::RMAG_W;
    localparam int P1_W   = scs_pkg::MAG_W + scs_pkg::RECIP_W;
    localparam int P2_W   = scs_pkg::MAG_W + scs_pkg::X2_W;

    localparam logic [SQ_W-1:0] SQ_HALF = SQ_W'(1) << (scs_pkg::WORK_FRAC - 1);
    localparam logic [P1_W-1:0] P1_HALF = P1_W'(1) << (scs_pkg::RECIP_FRAC - 1);
    localparam logic [P2_W-1:0] P2_HALF = P2_W'(1) << (scs_pkg::WORK_FRAC - 1);

    // flow control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] rdy;

    // front end: range reduction and r squared
    logic signed [PROD_W-1:0]         p_reg;
    logic signed [scs_pkg::ANGLE_W-1:0] ang_reg;
    logic signed [KM_W-1:0]           km_reg;
    logic signed [ASH_W-1:0]          ash_reg;
    logic signed [scs_pkg::RED_W-1:0] rraw_reg;
    logic signed [scs_pkg::RED_W-1:0] red_fold;
    logic signed [scs_pkg::R_W-1:0]   r_reg;
    logic [scs_pkg::R_W-1:0]          rabs;
    logic [scs_pkg::RMAG_W-1:0]       rmag;
    logic [SQ_W-1:0]                  rsq;
    logic [scs_pkg::X2_W-1:0]         x2_reg;
    logic [scs_pkg::MAG_W-1:0]        rmag_reg;
    logic                             rneg_reg;

    // series stages
    logic signed [scs_pkg::SUM_W-1:0] sin_sum_reg  [NT];
    logic signed [scs_pkg::SUM_W-1:0] cos_sum_reg  [NT];
    logic [scs_pkg::MAG_W-1:0]        sin_p1_reg   [NT-1];
    logic [scs_pkg::MAG_W-1:0]        cos_p1_reg   [NT-1];
    logic [scs_pkg::X2_W-1:0]         x2a_reg      [NT-1];
    logic                             sneg_a_reg   [NT-1];
    logic [scs_pkg::MAG_W-1:0]        sin_mag_reg  [NT-1];
    logic [scs_pkg::MAG_W-1:0]        cos_mag_reg  [NT-1];
    logic [scs_pkg::X2_W-1:0]         x2b_reg      [NT-1];
    logic                             sneg_b_reg   [NT-1];
    logic signed [scs_pkg::SUM_W-1:0] sin_sumb_reg [NT-1];
    logic signed [scs_pkg::SUM_W-1:0] cos_sumb_reg [NT-1];

    logic [scs_pkg::OUT_W-1:0] sine_reg;
    logic [scs_pkg::OUT_W-1:0] cosine_reg;

    function automatic logic [scs_pkg::OUT_W-1:0] sat_out(
        input logic signed [scs_pkg::SUM_W-1:0] v
    );
        logic [scs_pkg::SUM_W-scs_pkg::OUT_W+1:0] top;
        top = v[scs_pkg::SUM_W-1:scs_pkg::OUT_W-2];
        if (top == '0 || top == '1) begin
            return {v[scs_pkg::OUT_W-2:0], 1'b0};
        end else if (v[scs_pkg::SUM_W-1]) begin
            return scs_pkg::OUT_MIN;
        end else begin
            return scs_pkg::OUT_MAX;
        end
    endfunction

    // ---------------------------------------------------------------- flow control
    // a stage takes new data when it is empty or its contents move on
    assign rdy[NS-1] = !v_reg[NS-1] || m_ready;
    for (genvar i = 0; i < NS - 1; i++) begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= (rdy & {v_reg[NS-2:0], s_valid}) | (~rdy & v_reg);
        end
    end

    assign s_ready = rdy[0];
    assign m_valid = v_reg[NS-1];

    // ---------------------------------------------------------------- range reduction
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            p_reg   <= s_angle * $signed({1'b0, scs_pkg::INV_TWO_PI_Q32});
            ang_reg <= s_angle;
        end
    end

    // arithmetic shift of the product is the floor of angle / (2 pi)
    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            km_reg  <= $signed(p_reg[PROD_W-1:SHIFT]) * $signed({1'b0, scs_pkg::TWO_PI_Q29});
            ash_reg <= ASH_W'(ang_reg) <<< ASH_SH;
        end
    end

    // remainder is small, so the low bits of the difference are exact
    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            rraw_reg <= scs_pkg::RED_W'(ash_reg) - scs_pkg::RED_W'(km_reg);
        end
    end

    always_comb begin
        red_fold = rraw_reg;
        if (red_fold > scs_pkg::PI_RED) begin
            red_fold = red_fold - scs_pkg::TWO_PI_RED;
        end
        if (red_fold < -scs_pkg::PI_RED) begin
            red_fold = red_fold + scs_pkg::TWO_PI_RED;
        end
        if (red_fold > scs_pkg::PI_RED) begin
            red_fold = scs_pkg::PI_RED;
        end
        if (red_fold < -scs_pkg::PI_RED) begin
            red_fold = -scs_pkg::PI_RED;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            r_reg <= scs_pkg::R_W'(red_fold);
        end
    end

    always_comb begin
        rabs = r_reg[scs_pkg::R_W-1] ? scs_pkg::R_W'(-r_reg) : r_reg;
        rmag = rabs[scs_pkg::RMAG_W-1:0];
        rsq  = rmag * rmag + SQ_HALF;
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            x2_reg   <= rsq[scs_pkg::WORK_FRAC +: scs_pkg::X2_W];
            rmag_reg <= scs_pkg::MAG_W'(rmag);
            rneg_reg <= r_reg[scs_pkg::R_W-1];
        end
    end

    // ---------------------------------------------------------------- series
    // Terms are carried as magnitudes; the sign alternates from the first term.
    for (genvar n = 0; n < NT; n++) begin : g_term
        localparam int   SA  = A0 + 2 * n;
        localparam logic ODD = 1'(n % 2);

        logic [scs_pkg::MAG_W-1:0]        sin_mag;
        logic [scs_pkg::MAG_W-1:0]        cos_mag;
        logic signed [scs_pkg::SUM_W-1:0] sin_prev;
        logic signed [scs_pkg::SUM_W-1:0] cos_prev;
        logic                             sneg;
        logic [scs_pkg::X2_W-1:0]         x2_in;
        logic                             sin_neg;

        if (n == 0) begin : g_first
            assign sin_mag  = rmag_reg;
            assign cos_mag  = scs_pkg::ONE_Q29;
            assign sin_prev = '0;
            assign cos_prev = '0;
            assign sneg     = rneg_reg;
            assign x2_in    = x2_reg;
        end else begin : g_next
            assign sin_mag  = sin_mag_reg[n-1];
            assign cos_mag  = cos_mag_reg[n-1];
            assign sin_prev = sin_sumb_reg[n-1];
            assign cos_prev = cos_sumb_reg[n-1];
            assign sneg     = sneg_b_reg[n-1];
            assign x2_in    = x2b_reg[n-1];
        end

        assign sin_neg = sneg ^ ODD;

        always_ff @(posedge aclk) begin
            if (rdy[SA]) begin
                sin_sum_reg[n] <= sin_neg
                    ? sin_prev - $signed(scs_pkg::SUM_W'(sin_mag))
                    : sin_prev + $signed(scs_pkg::SUM_W'(sin_mag));
                cos_sum_reg[n] <= ODD
                    ? cos_prev - $signed(scs_pkg::SUM_W'(cos_mag))
                    : cos_prev + $signed(scs_pkg::SUM_W'(cos_mag));
            end
        end

        if (n < NT - 1) begin : g_mul
            localparam int SB = SA + 1;

            logic [P1_W-1:0] sin_p1;
            logic [P1_W-1:0] cos_p1;
            logic [P2_W-1:0] sin_p2;
            logic [P2_W-1:0] cos_p2;

            assign sin_p1 = sin_mag * scs_pkg::SINE_RECIP[n] + P1_HALF;
            assign cos_p1 = cos_mag * scs_pkg::COSINE_RECIP[n] + P1_HALF;

            always_ff @(posedge aclk) begin
                if (rdy[SA]) begin
                    sin_p1_reg[n] <= sin_p1[scs_pkg::RECIP_FRAC +: scs_pkg::MAG_W];
                    cos_p1_reg[n] <= cos_p1[scs_pkg::RECIP_FRAC +: scs_pkg::MAG_W];
                    x2a_reg[n]    <= x2_in;
                    sneg_a_reg[n] <= sneg;
                end
            end

            assign sin_p2 = sin_p1_reg[n] * x2a_reg[n] + P2_HALF;
            assign cos_p2 = cos_p1_reg[n] * x2a_reg[n] + P2_HALF;

            always_ff @(posedge aclk) begin
                if (rdy[SB]) begin
                    sin_mag_reg[n]  <= sin_p2[scs_pkg::WORK_FRAC +: scs_pkg::MAG_W];
                    cos_mag_reg[n]  <= cos_p2[scs_pkg::WORK_FRAC +: scs_pkg::MAG_W];
                    x2b_reg[n]      <= x2a_reg[n];
                    sneg_b_reg[n]   <= sneg_a_reg[n];
                    sin_sumb_reg[n] <= sin_sum_reg[n];
                    cos_sumb_reg[n] <= cos_sum_reg[n];
                end
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge aclk) begin
        if (rdy[NS-1]) begin
            sine_reg   <= sat_out(sin_sum_reg[NT-1]);
            cosine_reg <= sat_out(cos_sum_reg[NT-1]);
        end
    end

    assign m_sine_value   = $signed(sine_reg);
    assign m_cosine_value = $signed(cosine_reg);

    // ---------------------------------------------------------------- checks
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with output stage empty");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg && !m_ready) |-> !s_ready)
        else $error("input taken while every stage is occupied and stalled");

    a_enter_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[0])
        else $error("accepted transfer missing from first stage");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int SERIES_TERMS    = 10;
    localparam int ANGLE_FRAC_BITS = 24;
    localparam int WORK_FRAC_BITS  = 29;
    localparam int RECIP_ENTRIES   = 16;
    localparam int LATENCY         = 2 * SERIES_TERMS + 5;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_ANGLES   = 600;

    localparam longint INV_TWO_PI_Q32 = 64'sd683565276;
    localparam longint PI_Q29         = 64'sd1686629713;
    localparam longint TWO_PI_Q29     = 64'sd3373259426;

    // Angles in Q24 radians
    localparam int PI_Q24      = 52707179;
    localparam int TWO_PI_Q24  = 105414357;
    localparam int HALF_PI_Q24 = 26353589;

    typedef struct {
        logic signed [scs_pkg::OUT_W-1:0] sine;
        logic signed [scs_pkg::OUT_W-1:0] cosine;
    } trig_pair_t;

    typedef struct {
        logic signed [scs_pkg::ANGLE_W-1:0] angle;
        bit                                 drain_first;
    } angle_item_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic signed [scs_pkg::ANGLE_W-1:0] s_angle = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [scs_pkg::OUT_W-1:0]   m_sine_value;
    logic signed [scs_pkg::OUT_W-1:0]   m_cosine_value;

    angle_item_t angle_queue[$];
    trig_pair_t  expected_trig[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    sine_cosine_series_unit #(
        .SERIES_TERMS    (SERIES_TERMS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_angle        (s_angle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sine_value   (m_sine_value),
        .m_cosine_value (m_cosine_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // (a * b) / 2^sh, rounded half away from zero, unsigned product wraps at 64 bits
    function automatic longint round_mul_shift(longint a, longint unsigned b, int sh);
        bit              neg;
        longint unsigned mag;
        longint unsigned prod;
        neg  = a < 0;
        mag  = neg ? -a : a;
        prod = mag * b;
        prod = (prod + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint taylor_sum(longint first, longint x2, bit is_sine);
        longint          sum;
        longint          term;
        longint          t;
        longint unsigned div;
        longint unsigned recip;
        sum  = 0;
        term = first;
        for (int n = 0; n < SERIES_TERMS && n < RECIP_ENTRIES; n++) begin
            sum  += term;
            div   = is_sine ? (2 * n + 2) * (2 * n + 3) : (2 * n + 1) * (2 * n + 2);
            recip = ((64'd1 << 32) + div / 2) / div;
            t     = round_mul_shift(term, recip, 32);
            t     = round_mul_shift(t, longint'(x2), WORK_FRAC_BITS);
            term  = -t;
        end
        return sum;
    endfunction

    function automatic logic signed [scs_pkg::OUT_W-1:0] clamp_out(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic trig_pair_t predict_trig(logic signed [scs_pkg::ANGLE_W-1:0] angle);
        trig_pair_t      res;
        longint          a;
        longint          prod;
        longint          k;
        longint          r;
        longint          x2;
        longint unsigned m;
        int              sh;
        a    = longint'(angle);
        prod = a * INV_TWO_PI_Q32;
        sh   = ANGLE_FRAC_BITS + 32;
        // floor of angle / (2 pi)
        if (prod >= 0) begin
            k = prod >>> sh;
        end else begin
            m = -prod;
            k = -longint'((m + ((64'd1 << sh) - 64'd1)) >> sh);
        end
        r = (a <<< (WORK_FRAC_BITS - ANGLE_FRAC_BITS)) - k * TWO_PI_Q29;
        if (r > PI_Q29)  r -= TWO_PI_Q29;
        if (r < -PI_Q29) r += TWO_PI_Q29;
        if (r > PI_Q29)  r = PI_Q29;
        if (r < -PI_Q29) r = -PI_Q29;
        x2 = round_mul_shift(r, (r < 0) ? -r : r, WORK_FRAC_BITS);
        if (x2 < 0) x2 = -x2;
        res.sine   = clamp_out(taylor_sum(r, x2, 1'b1) * 2);
        res.cosine = clamp_out(taylor_sum(64'sd1 <<< WORK_FRAC_BITS, x2, 1'b0) * 2);
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver
    int send_gap    = 0;
    int send_steady = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_trig.push_back(predict_trig(s_angle));
                if (send_steady > 0) begin
                    send_steady--;
                    send_gap = 0;
                end else if ($urandom_range(0, 99) < 4) begin
                    send_steady = $urandom_range(20, 60);
                    send_gap    = 0;
                end else begin
                    send_gap = idle_cycles();
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (angle_queue.size() > 0 &&
                             !(angle_queue[0].drain_first && expected_trig.size() != 0)) begin
                    s_valid <= 1'b1;
                    s_angle <= angle_queue.pop_front().angle;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and result sink
    int sink_stall  = 0;
    int sink_steady = 0;

    always @(posedge aclk) begin
        trig_pair_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_trig.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result sine %0d cosine %0d",
                             $time, m_sine_value, m_cosine_value);
                end else begin
                    want = expected_trig.pop_front();
                    if (m_sine_value !== want.sine) begin
                        mismatch_count++;
                        $display("%0t: sine expected %0d got %0d",
                                 $time, want.sine, m_sine_value);
                    end
                    if (m_cosine_value !== want.cosine) begin
                        mismatch_count++;
                        $display("%0t: cosine expected %0d got %0d",
                                 $time, want.cosine, m_cosine_value);
                    end
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (sink_steady > 0)
                    sink_steady--;
                else if ($urandom_range(0, 99) < 3)
                    sink_steady = $urandom_range(40, 120);
                else if ($urandom_range(0, 99) < 30)
                    sink_stall = idle_cycles();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        int          directed[];
        angle_item_t item;
        int          pick;
        int          k;
        directed = '{
            0, 1, -1, 32'h7FFF_FFFF, 32'h8000_0000, PI_Q24, PI_Q24 + 1, -PI_Q24,
            -PI_Q24 - 1, TWO_PI_Q24, TWO_PI_Q24 + 1, TWO_PI_Q24 - 1, -TWO_PI_Q24,
            HALF_PI_Q24, -HALF_PI_Q24, 32'h0100_0000, -32'sh0100_0000,
            3 * TWO_PI_Q24, -3 * TWO_PI_Q24, 20 * TWO_PI_Q24, -20 * TWO_PI_Q24,
            32'h5555_5555, 32'hAAAA_AAAA
        };
        for (int i = 0; i < directed.size(); i++) begin
            item.angle       = directed[i];
            item.drain_first = 1'b0;
            angle_queue.push_back(item);
        end
        for (int i = 0; i < RANDOM_ANGLES; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                item.angle = $urandom;
            end else if (pick < 55) begin
                // near a multiple of pi/2, where sine or cosine crosses zero or peaks
                k          = $urandom_range(0, 162) - 81;
                item.angle = k * HALF_PI_Q24 + int'($urandom_range(0, 200)) - 100;
            end else if (pick < 80) begin
                item.angle = int'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
            end else begin
                // around whole turns, where the floor may be off by one
                k          = $urandom_range(0, 40) - 20;
                item.angle = k * TWO_PI_Q24 + int'($urandom_range(0, 8)) - 4;
            end
            // let the pipeline empty completely before a couple of transfers
            item.drain_first = (i == 0) || (i == RANDOM_ANGLES / 2);
            angle_queue.push_back(item);
        end

        @(posedge aclk);
        while (!aresetn || angle_queue.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_trig.size() != 0)
            @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);

        if (mismatch_count == 0 && expected_trig.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sine_cosine_series_unit.f]
src/scs_pkg.sv
src/sine_cosine_series_unit.sv
verif/testbench.sv
